FILE: hw/rtl/selsort_pkg.sv
// Shared types, sizes and the ordering key function for the selection sorter.
package selsort_pkg;

    // Capacity of one batch.
    localparam int MAX_ITEMS = 32;
    // Bits of an element index and of the element count (count may equal capacity).
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] value;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] sorted_value;
        logic        final_res;
        logic        overflow;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // store the incoming element
        logic sort_go;  // start the first selection pass
        logic scan_rd;  // read the next element of the current pass
        logic emit;     // deliver the minimum and complete the swap
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end; // the read issued now is the last of the pass
        logic pos_last; // the current position is the last of the batch
    } t_stat;

    // Maps a double bit pattern to an unsigned key with the same order.
    // Negative zero maps onto positive zero.
    function automatic logic [63:0] order_key(input logic [63:0] bits);
        logic [63:0] b;
        b = (bits == SIGN_BIT) ? 64'd0 : bits;
        if (b[63]) begin
            return ~b;
        end
        return b | SIGN_BIT;
    endfunction

endpackage

FILE: hw/rtl/selsort_ctrl.sv
// Controller state machine of the selection sorter.
module selsort_ctrl
    import selsort_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_last,
    input  t_stat    i_stat,
    output t_cmd     o_cmd,
    output logic     busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_LAST = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.sort_go = 1'b1;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.emit = 1'b1;
                n_state    = i_stat.pos_last ? S_IDLE : S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

FILE: hw/rtl/selsort_dp.sv
// Datapath of the selection sorter: element memory, counters and minimum search.
module selsort_dp
    import selsort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    output t_stat     o_stat,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic [63:0]      mem [MAX_ITEMS];
    logic [63:0]      r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_j;

    logic [63:0]      r_best_val;
    logic [IDX_W-1:0] r_best_idx;
    logic [63:0]      r_first;
    logic [63:0]      n_best_val;
    logic [IDX_W-1:0] n_best_idx;
    logic [63:0]      n_first;

    logic             full;
    logic [CNT_W-1:0] count_m1;

    assign full            = (r_count == CNT_W'(MAX_ITEMS));
    assign count_m1        = r_count - CNT_W'(1);
    assign o_stat.scan_end = (CNT_W'(r_j) == count_m1);
    assign o_stat.pos_last = (CNT_W'(r_pos) == count_m1);

    // Element memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem[r_count[IDX_W-1:0]] <= i_item.value;
        end else if (i_cmd.emit) begin
            mem[n_best_idx] <= n_first;
        end
        r_rd_data <= mem[r_j];
        r_rd_idx  <= r_j;
    end

    // Running minimum; the first read of a pass is the element at the position.
    always_comb begin
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_first    = r_first;
        if (r_rd_vld) begin
            if (r_rd_idx == r_pos) begin
                n_best_val = r_rd_data;
                n_best_idx = r_pos;
                n_first    = r_rd_data;
            end else if (order_key(r_rd_data) < order_key(r_best_val)) begin
                n_best_val = r_rd_data;
                n_best_idx = r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_first    <= n_first;
        if (i_cmd.emit) begin
            o_result.sorted_value <= n_best_val;
            o_result.final_res    <= o_stat.pos_last;
            o_result.overflow     <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pos    <= '0;
            r_j      <= '0;
            r_rd_vld <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            o_strobe <= i_cmd.emit;
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.sort_go) begin
                r_pos <= '0;
                r_j   <= '0;
            end else if (i_cmd.scan_rd) begin
                r_j <= r_j + IDX_W'(1);
            end else if (i_cmd.emit) begin
                r_pos <= r_pos + IDX_W'(1);
                r_j   <= r_pos + IDX_W'(1);
                if (o_stat.pos_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/ascending_selection_sort.sv
// Top level of the batch selection sorter for double bit patterns.
//
//  Channel  | Handshake              | Payload               | Direction
//  ---------+------------------------+-----------------------+----------
//  element  | start high, busy low   | i_item (value, last)  | in
//  result   | o_strobe, one cycle    | o_result (sorted_value,| out
//           |                        |   final_res, overflow)|
//
// Loading accepts one element per cycle; busy stays low while a batch fills.
// After the element marked last, pass p (p = 0 .. n-1) reads the remaining
// n-p elements one per cycle from the single read port of the element
// memory and then delivers the minimum of the pass.
// Reset is synchronous and active low; no clearing pass is needed.
// The receiver cannot stall: each result transfer lasts exactly one cycle.
module ascending_selection_sort
    import selsort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    // The controller sequences loading, the scan of each pass and the
    // delivery of each minimum. The datapath owns the memory and counters.
    t_cmd  cmd;
    t_stat stat;

    selsort_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_item.last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Each delivery writes the element that stood at the current position
    // into the slot where the minimum was found, completing the swap, while
    // the minimum itself goes straight to the result register.
    selsort_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: hw/rtl/selsort_chk.sv
// Port-level checker for the selection sorter and its bind.
module selsort_chk
    import selsort_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_item  i_item,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    a_no_result_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_item.last) |=> !o_strobe)
        else $error("result transfer after a non-final element");

    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.last) |=> busy)
        else $error("final element did not start sorting");

    a_final_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.final_res) |-> !busy)
        else $error("block still busy after final result");

    a_more_results_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.final_res) |=> busy)
        else $error("block went idle before final result");

endmodule

bind ascending_selection_sort selsort_chk u_selsort_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
